// ===== hdl/u2da_pkg.sv =====
// ----------------------------------------------------------------------------
// u2da_pkg
// Shared constants and types for the decimal ASCII formatter.
// ----------------------------------------------------------------------------
`default_nettype none

package u2da_pkg;

	localparam int BIN_W      = 32;
	localparam int NUM_DIGITS = 10;
	localparam int DIGIT_W    = 4;
	localparam int CHAR_W     = 6;
	localparam int TDATA_IN_W = 32;
	localparam int TDATA_OUT_W = 8;
	localparam int CNT_W      = $clog2(BIN_W);
	localparam int REM_W      = $clog2(NUM_DIGITS + 1);

	localparam logic [CHAR_W-1:0] CHAR_ZERO = 6'd48;
	localparam logic [CHAR_W-1:0] CHAR_LF   = 6'd10;

	typedef struct packed {
		logic clr;
		logic dabble;
		logic shift;
	} cell_ctl_t;

endpackage

`default_nettype wire

// ===== hdl/u2da_cell.sv =====
// ----------------------------------------------------------------------------
// u2da_cell
// One BCD digit of the conversion chain: add-3 and shift during conversion,
// digit-wide shift toward the top during readout.
// ----------------------------------------------------------------------------
`default_nettype none

module u2da_cell (
	input  logic                          clk,
	input  u2da_pkg::cell_ctl_t           ctl,
	input  logic                          bit_in,
	output logic                          bit_out,
	input  logic [u2da_pkg::DIGIT_W-1:0]  dig_in,
	output logic [u2da_pkg::DIGIT_W-1:0]  dig_out
);
	import u2da_pkg::*;

	logic [DIGIT_W-1:0] dig_q;
	logic [DIGIT_W-1:0] adj;

	always_comb begin
		adj = (dig_q >= DIGIT_W'(5)) ? dig_q + DIGIT_W'(3) : dig_q;
	end

	assign bit_out = adj[DIGIT_W-1];
	assign dig_out = dig_q;

	always_ff @(posedge clk) begin
		if (ctl.clr) begin
			dig_q <= '0;
		end else if (ctl.dabble) begin
			dig_q <= {adj[DIGIT_W-2:0], bit_in};
		end else if (ctl.shift) begin
			dig_q <= dig_in;
		end
	end

endmodule

`default_nettype wire

// ===== hdl/u32_to_decimal_ascii.sv =====
// ----------------------------------------------------------------------------
// u32_to_decimal_ascii
// Renders an unsigned 32-bit value as decimal ASCII, one character per beat.
// ----------------------------------------------------------------------------
// Each request carries a value and a newline flag; the block answers with the
// decimal digits, most significant first, leading zeros dropped (zero gives a
// single '0'), then a line feed if the flag is set, with tlast on the final
// character. A row of ten BCD cells converts the value by shift-and-add-3,
// then the digits shift out of the top cell: leading zeros are skipped
// first, then the characters are sent as the output takes them. The next
// request is taken once the last character has moved into the output
// register.
`default_nettype none

module u32_to_decimal_ascii (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 s_tvalid,
	output logic                                 s_tready,
	input  logic [u2da_pkg::TDATA_IN_W-1:0]      s_tdata,  // [31:0] value
	input  logic                                 s_tuser,  // [0] add_newline
	output logic                                 m_tvalid,
	input  logic                                 m_tready,
	output logic [u2da_pkg::TDATA_OUT_W-1:0]     m_tdata,  // [5:0] char_code
	output logic                                 m_tlast   // is_last
);
	import u2da_pkg::*;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_CONV = 3'd1;
	localparam logic [2:0] ST_SKIP = 3'd2;
	localparam logic [2:0] ST_EMIT = 3'd3;
	localparam logic [2:0] ST_LF   = 3'd4;

	logic [2:0]        state_q;
	logic [BIN_W-1:0]  bin_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [REM_W-1:0]  rem_q;
	logic              nl_q;
	logic              out_valid_q;
	logic [CHAR_W-1:0] out_char_q;
	logic              out_last_q;

	cell_ctl_t         ctl;
	logic              out_free;
	logic              out_load;
	logic              s_acc;
	logic [NUM_DIGITS-1:0]  carry;
	logic [DIGIT_W-1:0]     dig [NUM_DIGITS];
	logic [DIGIT_W-1:0]     top;

	assign top      = dig[NUM_DIGITS-1];
	assign out_free = !out_valid_q || m_tready;
	assign out_load = out_free && ((state_q == ST_EMIT) || (state_q == ST_LF));
	assign s_tready = (state_q == ST_IDLE);
	assign s_acc    = s_tvalid && s_tready;

	always_comb begin
		ctl.clr    = s_acc;
		ctl.dabble = (state_q == ST_CONV);
		ctl.shift  = ((state_q == ST_SKIP) && (top == '0) && (rem_q > REM_W'(1)))
		          || ((state_q == ST_EMIT) && out_free);
	end

	genvar gi;
	generate
		for (gi = 0; gi < NUM_DIGITS; gi++) begin : g_cell
			if (gi == 0) begin : g_first
				u2da_cell u_cell (
					.clk     (clk),
					.ctl     (ctl),
					.bit_in  (bin_q[BIN_W-1]),
					.bit_out (carry[gi]),
					.dig_in  ({DIGIT_W{1'b0}}),
					.dig_out (dig[gi])
				);
			end else begin : g_rest
				u2da_cell u_cell (
					.clk     (clk),
					.ctl     (ctl),
					.bit_in  (carry[gi-1]),
					.bit_out (carry[gi]),
					.dig_in  (dig[gi-1]),
					.dig_out (dig[gi])
				);
			end
		end
	endgenerate

	always_ff @(posedge clk) begin
		if (s_acc) begin
			bin_q <= s_tdata[BIN_W-1:0];
			nl_q  <= s_tuser;
		end else if (state_q == ST_CONV) begin
			bin_q <= {bin_q[BIN_W-2:0], 1'b0};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			rem_q       <= '0;
			out_valid_q <= 1'b0;
			out_char_q  <= '0;
			out_last_q  <= 1'b0;
		end else begin
			if (out_valid_q && m_tready && !out_load) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (s_acc) begin
						cnt_q   <= CNT_W'(BIN_W - 1);
						state_q <= ST_CONV;
					end
				end
				ST_CONV: begin
					cnt_q <= cnt_q - CNT_W'(1);
					if (cnt_q == '0) begin
						rem_q   <= REM_W'(NUM_DIGITS);
						state_q <= ST_SKIP;
					end
				end
				ST_SKIP: begin
					if (ctl.shift) begin
						rem_q <= rem_q - REM_W'(1);
					end else begin
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						out_char_q  <= CHAR_ZERO + CHAR_W'(top);
						out_last_q  <= (rem_q == REM_W'(1)) && !nl_q;
						rem_q       <= rem_q - REM_W'(1);
						if (rem_q == REM_W'(1)) begin
							state_q <= nl_q ? ST_LF : ST_IDLE;
						end
					end
				end
				ST_LF: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						out_char_q  <= CHAR_LF;
						out_last_q  <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {{(TDATA_OUT_W-CHAR_W){1'b0}}, out_char_q};
	assign m_tlast  = out_last_q;

endmodule

`default_nettype wire

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Stream-level check of the decimal ASCII formatter.
// ----------------------------------------------------------------------------
// Values with a newline flag go in on the slave side and characters come back
// on the master side. A scoreboard works out the decimal digits of every
// accepted request and compares each returned character and its tlast flag in
// order. A directed set of edge values comes first, then random values spread
// over all digit counts, with random gaps on both sides, a stretch with no
// gaps, and one long output stall that backs up the input.

class decimal_char_board;
	typedef struct {
		logic [5:0] code;
		logic       last;
	} char_t;

	char_t pending_chars[$];
	int    mismatches;
	int    chars_seen;

	function void flag(string msg);
		mismatches++;
		if (mismatches <= 10)
			$display("%0t ns: MISMATCH %s", $time, msg);
	endfunction

	// work out the characters of one request, most significant digit first
	function void note_value(logic [31:0] value, logic nl);
		logic [31:0] rest;
		logic [3:0]  digs[10];
		int          nd;
		char_t       c;
		rest = value;
		nd = 0;
		do begin
			digs[nd] = 4'(rest % 10);
			rest = rest / 10;
			nd++;
		end while (rest != 0 && nd < 10);
		for (int k = nd - 1; k >= 0; k--) begin
			c.code = u2da_pkg::CHAR_ZERO + digs[k];
			c.last = (k == 0) && !nl;
			pending_chars.push_back(c);
		end
		if (nl) begin
			c.code = u2da_pkg::CHAR_LF;
			c.last = 1'b1;
			pending_chars.push_back(c);
		end
	endfunction

	function void check_char(logic [5:0] code, logic last);
		char_t want;
		chars_seen++;
		if (pending_chars.size() == 0) begin
			flag($sformatf("unexpected character code %0d last %0b", code, last));
			return;
		end
		want = pending_chars.pop_front();
		if (code !== want.code)
			flag($sformatf("char_code expected %0d actual %0d", want.code, code));
		if (last !== want.last)
			flag($sformatf("tlast expected %0b actual %0b (code %0d)", want.last, last,
				want.code));
	endfunction
endclass

module testbench;
	import u2da_pkg::*;

	localparam int CLK_HALF  = 4;
	localparam int N_RANDOM  = 210;
	localparam int HOLD_LEN  = 400;

	logic                   clk      = 1'b0;
	logic                   arst_n   = 1'b0;
	logic                   s_tvalid = 1'b0;
	logic                   s_tready;
	logic [TDATA_IN_W-1:0]  s_tdata  = '0;  // [31:0] value
	logic                   s_tuser  = 1'b0;  // [0] add_newline
	logic                   m_tvalid;
	logic                   m_tready = 1'b0;
	logic [TDATA_OUT_W-1:0] m_tdata;        // [5:0] char_code
	logic                   m_tlast;        // is_last

	decimal_char_board board = new();

	int requests_sent;
	int lf_requests;
	int ten_digit_requests;
	bit calm;

	int unsigned pow10[10] = '{1, 10, 100, 1000, 10000, 100000, 1000000, 10000000,
		100000000, 1000000000};

	always #(CLK_HALF) clk = ~clk;

	u32_to_decimal_ascii dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	task automatic offer_value(input logic [31:0] value, input logic nl);
		int gap;
		gap = 0;
		if (!calm && $urandom_range(99) < 35)
			gap = $urandom_range(50, 1);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= value;
		s_tuser  <= nl;
		do @(posedge clk); while (!s_tready);
		board.note_value(value, nl);
		requests_sent++;
		if (nl)
			lf_requests++;
		if (value >= 32'd1000000000)
			ten_digit_requests++;
	endtask

	function automatic logic [31:0] pick_value();
		int          n;
		int unsigned lo;
		int unsigned hi;
		case ($urandom_range(9))
			0, 1, 2, 3, 4, 5: begin
				n  = $urandom_range(10, 1);
				lo = (n == 1) ? 0 : pow10[n-1];
				hi = (n == 10) ? 32'hFFFF_FFFF : pow10[n] - 1;
				return $urandom_range(hi, lo);
			end
			6, 7: return $urandom;
			8: return pow10[$urandom_range(9, 1)] + $urandom_range(2) - 1;
			default: return $urandom_range(20);
		endcase
	endfunction

	// receiver: check, then pick the next tready
	initial begin
		int hold_left;
		bit pressure_done;
		hold_left = 0;
		pressure_done = 0;
		forever begin
			@(posedge clk);
			if (arst_n && m_tvalid && m_tready)
				board.check_char(m_tdata[5:0], m_tlast);
			if (!pressure_done && requests_sent >= 40) begin
				hold_left = HOLD_LEN;
				pressure_done = 1;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else if (calm) begin
				m_tready <= 1'b1;
			end else begin
				m_tready <= ($urandom_range(99) >= 35);
			end
		end
	end

	initial begin
		#(2_000_000);
		$display("u32_to_decimal_ascii verification failed");
		$finish;
	end

	initial begin
		int leftover;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		offer_value(32'd0, 1'b0);
		offer_value(32'd0, 1'b1);
		offer_value(32'd1, 1'b0);
		offer_value(32'd9, 1'b1);
		offer_value(32'd10, 1'b0);
		offer_value(32'd99, 1'b1);
		offer_value(32'd100, 1'b0);
		offer_value(32'd101, 1'b1);
		offer_value(32'd999999999, 1'b0);
		offer_value(32'd999999999, 1'b1);
		offer_value(32'd1000000000, 1'b0);
		offer_value(32'd1000000000, 1'b1);
		offer_value(32'd1234567890, 1'b1);
		offer_value(32'd2147483648, 1'b0);
		offer_value(32'd4000000000, 1'b1);
		offer_value(32'hAAAA_AAAA, 1'b0);
		offer_value(32'h5555_5555, 1'b1);
		offer_value(32'hFFFF_FFFF, 1'b0);
		offer_value(32'hFFFF_FFFF, 1'b1);
		offer_value(32'd4294967290, 1'b1);

		for (int i = 0; i < N_RANDOM; i++) begin
			calm = (i >= 100 && i < 150);
			offer_value(pick_value(), 1'($urandom_range(1)));
		end
		calm = 0;
		s_tvalid <= 1'b0;

		while (board.pending_chars.size() != 0) @(posedge clk);
		repeat (60) @(posedge clk);

		leftover = board.pending_chars.size();
		if (leftover != 0)
			board.flag($sformatf("%0d characters never arrived", leftover));

		$display("Rendered %0d values (%0d with line feed, %0d of ten digits) into %0d characters.",
			requests_sent, lf_requests, ten_digit_requests, board.chars_seen);
		$display("Output stalls, one long backpressure hold and a gap-free stretch included; %0d mismatches.",
			board.mismatches);
		if (board.mismatches == 0)
			$display("u32_to_decimal_ascii verification clean");
		else
			$display("u32_to_decimal_ascii verification failed");
		$finish;
	end

endmodule
